// ===== rtl/sha224bh_pkg.sv =====
// ============================================================================
// sha224bh_pkg
// Shared types, constants and round functions of the SHA-224 block hasher.
// ============================================================================
package sha224bh_pkg;

    localparam int WORD_W       = 32;
    localparam int WINDOW_DEPTH = 16;
    localparam int WINDOW_AW    = $clog2(WINDOW_DEPTH);
    localparam int HASH_WORDS   = 8;
    localparam int DIGEST_WORDS = 7;
    localparam int NUM_ROUNDS   = 64;
    localparam int ROUND_W      = $clog2(NUM_ROUNDS);
    localparam int INDEX_W      = 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
    } working_t;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t small_sig0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sig0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t init_hash(logic [2:0] i);
        word_t v;
        case (i)
            3'd0:    v = 32'hc1059ed8;
            3'd1:    v = 32'h367cd507;
            3'd2:    v = 32'h3070dd17;
            3'd3:    v = 32'hf70e5939;
            3'd4:    v = 32'hffc00b31;
            3'd5:    v = 32'h68581511;
            3'd6:    v = 32'h64f98fa7;
            3'd7:    v = 32'hbefa4fa4;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t round_k(logic [ROUND_W-1:0] t);
        word_t v;
        case (t)
            6'd0:    v = 32'h428a2f98;
            6'd1:    v = 32'h71374491;
            6'd2:    v = 32'hb5c0fbcf;
            6'd3:    v = 32'he9b5dba5;
            6'd4:    v = 32'h3956c25b;
            6'd5:    v = 32'h59f111f1;
            6'd6:    v = 32'h923f82a4;
            6'd7:    v = 32'hab1c5ed5;
            6'd8:    v = 32'hd807aa98;
            6'd9:    v = 32'h12835b01;
            6'd10:   v = 32'h243185be;
            6'd11:   v = 32'h550c7dc3;
            6'd12:   v = 32'h72be5d74;
            6'd13:   v = 32'h80deb1fe;
            6'd14:   v = 32'h9bdc06a7;
            6'd15:   v = 32'hc19bf174;
            6'd16:   v = 32'he49b69c1;
            6'd17:   v = 32'hefbe4786;
            6'd18:   v = 32'h0fc19dc6;
            6'd19:   v = 32'h240ca1cc;
            6'd20:   v = 32'h2de92c6f;
            6'd21:   v = 32'h4a7484aa;
            6'd22:   v = 32'h5cb0a9dc;
            6'd23:   v = 32'h76f988da;
            6'd24:   v = 32'h983e5152;
            6'd25:   v = 32'ha831c66d;
            6'd26:   v = 32'hb00327c8;
            6'd27:   v = 32'hbf597fc7;
            6'd28:   v = 32'hc6e00bf3;
            6'd29:   v = 32'hd5a79147;
            6'd30:   v = 32'h06ca6351;
            6'd31:   v = 32'h14292967;
            6'd32:   v = 32'h27b70a85;
            6'd33:   v = 32'h2e1b2138;
            6'd34:   v = 32'h4d2c6dfc;
            6'd35:   v = 32'h53380d13;
            6'd36:   v = 32'h650a7354;
            6'd37:   v = 32'h766a0abb;
            6'd38:   v = 32'h81c2c92e;
            6'd39:   v = 32'h92722c85;
            6'd40:   v = 32'ha2bfe8a1;
            6'd41:   v = 32'ha81a664b;
            6'd42:   v = 32'hc24b8b70;
            6'd43:   v = 32'hc76c51a3;
            6'd44:   v = 32'hd192e819;
            6'd45:   v = 32'hd6990624;
            6'd46:   v = 32'hf40e3585;
            6'd47:   v = 32'h106aa070;
            6'd48:   v = 32'h19a4c116;
            6'd49:   v = 32'h1e376c08;
            6'd50:   v = 32'h2748774c;
            6'd51:   v = 32'h34b0bcb5;
            6'd52:   v = 32'h391c0cb3;
            6'd53:   v = 32'h4ed8aa4a;
            6'd54:   v = 32'h5b9cca4f;
            6'd55:   v = 32'h682e6ff3;
            6'd56:   v = 32'h748f82ee;
            6'd57:   v = 32'h78a5636f;
            6'd58:   v = 32'h84c87814;
            6'd59:   v = 32'h8cc70208;
            6'd60:   v = 32'h90befffa;
            6'd61:   v = 32'ha4506ceb;
            6'd62:   v = 32'hbef9a3f7;
            6'd63:   v = 32'hc67178f2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sha224bh_ram.sv =====
// ============================================================================
// sha224bh_ram
// Generic RAM with one write port and two registered read ports.
// ============================================================================
module sha224bh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/sha224bh_round.sv =====
// ============================================================================
// sha224bh_round
// One SHA-224 round: message schedule word and working variable update.
// ============================================================================
module sha224bh_round
    import sha224bh_pkg::*;
(
    input  logic     expand,
    input  word_t    w_old,
    input  word_t    w_m15,
    input  word_t    w_m7,
    input  word_t    w_m2,
    input  word_t    k,
    input  working_t vars,
    output word_t    w,
    output working_t vars_next
);

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    always_comb
    begin
        if (expand)
        begin
            w = small_sig1(w_m2) + w_m7 + small_sig0(w_m15) + w_old;
        end
        else
        begin
            w = w_old;
        end
        ch  = (vars.e & vars.f) ^ (~vars.e & vars.g);
        maj = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
        t1  = vars.h + big_sig1(vars.e) + ch + k + w;
        t2  = big_sig0(vars.a) + maj;
        vars_next.h = vars.g;
        vars_next.g = vars.f;
        vars_next.f = vars.e;
        vars_next.e = vars.d + t1;
        vars_next.d = vars.c;
        vars_next.c = vars.b;
        vars_next.b = vars.a;
        vars_next.a = t1 + t2;
    end

endmodule

// ===== rtl/sha224_block_hasher_top.sv =====
// ============================================================================
// sha224_block_hasher_top
// SHA-224 compression engine over padded 32-bit message words.
//
// Channel   Direction  Handshake               Beat contents
// msg       in         msg_valid/msg_ready     message_word, start_message,
//                                              end_message
// digest    out        digest_valid/digest_ready digest_word, word_index,
//                                              last_word
//
// Message words are taken at one per cycle while idle. The sixteenth word of
// a block starts the busy phase: schedule RAM read port priming in S_PRIME0
// and S_PRIME1, 64 rounds at one round per cycle, and one hash update.
// A word marked as the message end then yields seven digest beats.
// Reset loads the initial hash values at once; no clearing pass is needed.
// A stalled digest beat holds the block; no new word is taken meanwhile.
// ============================================================================
module sha224_block_hasher_top
    import sha224bh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    output logic               msg_ready,
    input  logic [31:0]        message_word,
    input  logic               start_message,
    input  logic               end_message,
    output logic               digest_valid,
    input  logic               digest_ready,
    output logic [31:0]        digest_word,
    output logic [INDEX_W-1:0] word_index,
    output logic               last_word
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRIME0 = 3'd1;
    localparam logic [2:0] S_PRIME1 = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [INDEX_W-1:0]   LAST_INDEX = INDEX_W'(DIGEST_WORDS - 1);
    localparam logic [WINDOW_AW-1:0] LAST_SLOT  = WINDOW_AW'(WINDOW_DEPTH - 1);
    localparam logic [ROUND_W-1:0]   LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [WINDOW_AW-1:0] word_count_reg;
    logic [WINDOW_AW-1:0] word_count_next;
    logic [ROUND_W-1:0]   round_reg;
    logic [ROUND_W-1:0]   round_next;
    logic                 end_pend_reg;
    logic                 end_pend_next;
    logic [INDEX_W-1:0]   index_reg;
    logic [INDEX_W-1:0]   index_next;

    word_t    hash_reg [HASH_WORDS];
    working_t vars_reg;
    word_t    old_w_reg;
    word_t    wm1_reg;
    word_t    wm2_reg;

    logic                 accept;
    logic [WINDOW_AW-1:0] eff_count;
    logic                 ram_we;
    logic [WINDOW_AW-1:0] ram_waddr;
    word_t                ram_wdata;
    logic [WINDOW_AW-1:0] ram_raddr_a;
    logic [WINDOW_AW-1:0] ram_raddr_b;
    word_t                ram_rdata_a;
    word_t                ram_rdata_b;
    logic                 expand;
    word_t                round_w;
    working_t             round_vars;

    assign msg_ready    = (state_reg == S_IDLE);
    assign accept       = msg_valid && msg_ready;
    assign eff_count    = start_message ? '0 : word_count_reg;
    assign expand       = (round_reg[ROUND_W-1:WINDOW_AW] != '0);

    assign digest_valid = (state_reg == S_OUT);
    assign digest_word  = hash_reg[index_reg];
    assign word_index   = index_reg;
    assign last_word    = (index_reg == LAST_INDEX);

    always_comb
    begin
        ram_we    = accept || ((state_reg == S_ROUND) && expand);
        ram_waddr = accept ? eff_count : round_reg[WINDOW_AW-1:0];
        ram_wdata = accept ? message_word : round_w;
        case (state_reg)
            S_PRIME0:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = '0;
            end
            S_PRIME1:
            begin
                ram_raddr_a = WINDOW_AW'(1);
                ram_raddr_b = WINDOW_AW'(9);
            end
            default:
            begin
                ram_raddr_a = round_reg[WINDOW_AW-1:0] + WINDOW_AW'(2);
                ram_raddr_b = round_reg[WINDOW_AW-1:0] + WINDOW_AW'(10);
            end
        endcase
    end

    sha224bh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    sha224bh_round u_round (
        .expand    (expand),
        .w_old     (old_w_reg),
        .w_m15     (ram_rdata_a),
        .w_m7      (ram_rdata_b),
        .w_m2      (wm2_reg),
        .k         (round_k(round_reg)),
        .vars      (vars_reg),
        .w         (round_w),
        .vars_next (round_vars)
    );

    always_comb
    begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        round_next      = round_reg;
        end_pend_next   = end_pend_reg;
        index_next      = index_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_count_next = eff_count + WINDOW_AW'(1);
                    end_pend_next   = end_message;
                    if (eff_count == LAST_SLOT)
                    begin
                        state_next = S_PRIME0;
                    end
                    else if (end_message)
                    begin
                        state_next      = S_OUT;
                        word_count_next = '0;
                        index_next      = '0;
                    end
                end
            end
            S_PRIME0:
            begin
                state_next = S_PRIME1;
            end
            S_PRIME1:
            begin
                state_next = S_ROUND;
                round_next = '0;
            end
            S_ROUND:
            begin
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                index_next = '0;
                state_next = end_pend_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (digest_ready)
                begin
                    if (index_reg == LAST_INDEX)
                    begin
                        state_next = S_IDLE;
                        index_next = '0;
                    end
                    else
                    begin
                        index_next = index_reg + INDEX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            word_count_reg <= '0;
            round_reg      <= '0;
            end_pend_reg   <= 1'b0;
            index_reg      <= '0;
            vars_reg       <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            round_reg      <= round_next;
            end_pend_reg   <= end_pend_next;
            index_reg      <= index_next;
            if (accept && start_message)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= init_hash(3'(i));
                end
            end
            if (state_reg == S_PRIME1)
            begin
                vars_reg <= '{hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                              hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
            end
            if (state_reg == S_ROUND)
            begin
                vars_reg <= round_vars;
            end
            if (state_reg == S_FINAL)
            begin
                hash_reg[0] <= hash_reg[0] + vars_reg.a;
                hash_reg[1] <= hash_reg[1] + vars_reg.b;
                hash_reg[2] <= hash_reg[2] + vars_reg.c;
                hash_reg[3] <= hash_reg[3] + vars_reg.d;
                hash_reg[4] <= hash_reg[4] + vars_reg.e;
                hash_reg[5] <= hash_reg[5] + vars_reg.f;
                hash_reg[6] <= hash_reg[6] + vars_reg.g;
                hash_reg[7] <= hash_reg[7] + vars_reg.h;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PRIME1) || (state_reg == S_ROUND))
        begin
            old_w_reg <= ram_rdata_a;
        end
        if (state_reg == S_ROUND)
        begin
            wm1_reg <= round_w;
            wm2_reg <= wm1_reg;
        end
    end

endmodule

// ===== rtl/sha224bh_checker.sv =====
// ============================================================================
// sha224bh_checker
// Port-level checks of the SHA-224 block hasher, bound to the top level.
// ============================================================================
module sha224bh_checker
    import sha224bh_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               msg_valid,
    input logic               msg_ready,
    input logic               end_message,
    input logic               digest_valid,
    input logic               digest_ready,
    input logic [31:0]        digest_word,
    input logic [INDEX_W-1:0] word_index,
    input logic               last_word
);

    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=>
            digest_valid && $stable(digest_word) && $stable(word_index))
        else $error("Stalled digest beat changed.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        msg_ready |-> !digest_valid)
        else $error("Message taken while digest beats are pending.");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !last_word |=>
            digest_valid && (word_index == $past(word_index) + 3'd1))
        else $error("Digest beats out of order.");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && end_message |=> !msg_ready)
        else $error("Message end beat did not hold off the next word.");

endmodule

bind sha224_block_hasher_top sha224bh_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .end_message  (end_message),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
);
